/* design/snac_pkg.sv */
`timescale 1ns / 1ps
package snac_pkg;
	localparam int Neurons = 1024;
	localparam int DelaySlots = 4;
	localparam int RefractoryTicks = 2;
	localparam int NW = 10;
	localparam int SW = 2;
	localparam int RW = 2;
	localparam int RingW = NW + SW;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_SYN = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;
	localparam logic [1:0] ACT_RSVD = 2'd3;

	localparam logic [2:0] REG_REST = 3'd0;
	localparam logic [2:0] REG_LEAK = 3'd1;
	localparam logic [2:0] REG_TH_EXC = 3'd2;
	localparam logic [2:0] REG_SL_EXC = 3'd3;
	localparam logic [2:0] REG_BS_EXC = 3'd4;
	localparam logic [2:0] REG_TH_INH = 3'd5;
	localparam logic [2:0] REG_SL_INH = 3'd6;
	localparam logic [2:0] REG_BS_INH = 3'd7;

	typedef struct packed {
		logic [1:0] action;
		logic [9:0] neuron_index;
		logic [1:0] time_slot;
		logic signed [23:0] value;
		logic neuron_kind;
		logic [1:0] delay_ticks;
		logic [15:0] random_draw;
	} in_item_t;

	typedef struct packed {
		logic [9:0] out_neuron;
		logic fired;
		logic signed [23:0] potential;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [23:0] data;
	} cfg_item_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic compute;
		logic write;
		logic clear_step;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_load;
	} dp_status_t;
endpackage

/* design/snac_if.sv */
`timescale 1ns / 1ps
interface snac_in_if;
	import snac_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface snac_out_if;
	import snac_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface snac_cfg_if;
	import snac_pkg::*;
	logic valid;
	logic ready;
	cfg_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/snac_datapath.sv */
`timescale 1ns / 1ps
module snac_datapath (
	input logic clk,
	input logic arst_n,
	input snac_pkg::dp_cmd_t cmd,
	output snac_pkg::dp_status_t status,
	input snac_pkg::in_item_t in_item,
	input snac_pkg::cfg_item_t cfg_item,
	input logic cfg_we,
	output snac_pkg::out_item_t result
);
	import snac_pkg::*;

	logic signed [23:0] rest_q, th_exc_q, th_inh_q;
	logic [15:0] leak_q, sl_exc_q, bs_exc_q, sl_inh_q, bs_inh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= -24'sd4259840;
			leak_q <= 16'd58982;
			th_exc_q <= -24'sd4227072;
			sl_exc_q <= 16'd2425;
			bs_exc_q <= 16'd0;
			th_inh_q <= -24'sd4134052;
			sl_inh_q <= 16'd3277;
			bs_inh_q <= 16'd19661;
		end else if (cfg_we) begin
			case (cfg_item.index)
				REG_REST: rest_q <= cfg_item.data;
				REG_LEAK: leak_q <= cfg_item.data[15:0];
				REG_TH_EXC: th_exc_q <= cfg_item.data;
				REG_SL_EXC: sl_exc_q <= cfg_item.data[15:0];
				REG_BS_EXC: bs_exc_q <= cfg_item.data[15:0];
				REG_TH_INH: th_inh_q <= cfg_item.data;
				REG_SL_INH: sl_inh_q <= cfg_item.data[15:0];
				REG_BS_INH: bs_inh_q <= cfg_item.data[15:0];
				default: ;
			endcase
		end
	end

	// Neuron state: potential, refractory count and kind share one word.
	logic [24+RW:0] nmem [Neurons];
	logic signed [23:0] ring [Neurons*DelaySlots];

	in_item_t it_q;
	logic [SW-1:0] clr_q;
	logic signed [23:0] v_rd_q, ring_rd_q;
	logic [RW-1:0] rc_rd_q;
	logic kind_rd_q;
	logic signed [23:0] v_int_q;
	logic fired_q;
	logic signed [23:0] v_new_q;
	logic [9:0] out_n_q;

	logic [SW-1:0] syn_slot, rd_slot;
	assign syn_slot = it_q.time_slot + it_q.delay_ticks;
	assign rd_slot = (it_q.action == ACT_SYN) ? syn_slot : it_q.time_slot;

	always_ff @(posedge clk) begin
		if (cmd.capture) it_q <= in_item;
		if (cmd.read) begin
			{v_rd_q, rc_rd_q, kind_rd_q} <= nmem[it_q.neuron_index];
			ring_rd_q <= ring[{it_q.neuron_index, rd_slot}];
		end
	end

	// Tick arithmetic: the leak product is registered before the firing product.
	logic signed [24:0] d;
	logic signed [41:0] prod;
	logic signed [26:0] acc;
	logic signed [23:0] v_int, v_sat, th;
	logic [15:0] sl, bs;
	logic signed [24:0] vd;
	logic [40:0] pprod;
	logic [25:0] prob;
	logic refr;
	logic fire;
	logic signed [24:0] wsum;
	logic signed [23:0] wsat;
	logic fired_next;
	logic signed [23:0] v_next;
	logic [RW-1:0] rc_next;

	always_comb begin
		refr = rc_rd_q < RW'(RefractoryTicks);
		d = 25'(v_rd_q) - 25'(rest_q);
		prod = 42'(d) * $signed({26'd0, leak_q});
		acc = 27'(rest_q) + 27'(prod >>> 16) + 27'(ring_rd_q) + 27'(it_q.value);
		if (acc > 27'sd8388607) v_sat = 24'sd8388607;
		else if (acc < -27'sd8388608) v_sat = -24'sd8388608;
		else v_sat = acc[23:0];
		v_int = refr ? v_rd_q : v_sat;
		th = kind_rd_q ? th_inh_q : th_exc_q;
		sl = kind_rd_q ? sl_inh_q : sl_exc_q;
		bs = kind_rd_q ? bs_inh_q : bs_exc_q;
		vd = 25'(v_int_q) - 25'(th);
		pprod = vd[24:0] * sl;
		prob = 26'(pprod >> 16) + 26'(bs);
		fire = (v_int_q > th) && ((prob >= 26'd65536) || (26'(it_q.random_draw) < prob));
		wsum = 25'(ring_rd_q) + 25'(it_q.value);
		if (wsum > 25'sd8388607) wsat = 24'sd8388607;
		else if (wsum < -25'sd8388608) wsat = -24'sd8388608;
		else wsat = wsum[23:0];
		fired_next = 1'b0;
		v_next = v_rd_q;
		rc_next = rc_rd_q;
		case (it_q.action)
			ACT_TICK: begin
				fired_next = fire;
				v_next = fire ? rest_q : v_int_q;
				rc_next = fire ? '0 : (refr ? rc_rd_q + 1'b1 : rc_rd_q);
			end
			ACT_LOAD: begin
				v_next = it_q.value;
				rc_next = RW'(RefractoryTicks);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.compute) v_int_q <= v_int;
		if (cmd.write) begin
			fired_q <= fired_next;
			v_new_q <= v_next;
			out_n_q <= it_q.neuron_index;
			case (it_q.action)
				ACT_LOAD: begin
					nmem[it_q.neuron_index] <= {it_q.value, RW'(RefractoryTicks),
						it_q.neuron_kind};
				end
				ACT_SYN: ring[{it_q.neuron_index, rd_slot}] <= wsat;
				ACT_TICK: begin
					nmem[it_q.neuron_index] <= {v_next, rc_next, kind_rd_q};
					ring[{it_q.neuron_index, rd_slot}] <= '0;
				end
				default: ;
			endcase
		end
		if (cmd.clear_step) ring[{it_q.neuron_index, clr_q}] <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.capture) clr_q <= '0;
		else if (cmd.clear_step) clr_q <= clr_q + 1'b1;
	end

	assign status.clear_last = clr_q == SW'(DelaySlots - 1);
	assign status.is_load = it_q.action == ACT_LOAD;
	assign result.out_neuron = out_n_q;
	assign result.fired = fired_q;
	assign result.potential = v_new_q;
endmodule

/* design/snac_ctrl.sv */
`timescale 1ns / 1ps
module snac_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input snac_pkg::dp_status_t status,
	output snac_pkg::dp_cmd_t cmd
);
	import snac_pkg::*;

	typedef enum logic [2:0] {IDLE, READ, CALC, DECIDE, CLEAR} state_t;
	state_t state_q;
	logic out_free;

	assign in_ready = (state_q == IDLE);
	assign out_free = !out_valid || out_ready;
	always_comb begin
		cmd = '0;
		cmd.capture = in_ready && in_valid;
		cmd.read = state_q == READ;
		cmd.compute = state_q == CALC;
		cmd.write = (state_q == DECIDE) && out_free;
		cmd.clear_step = state_q == CLEAR;
	end

	// An item commits in DECIDE only once the result register can take its result;
	// a load item then sweeps its ring slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				IDLE: if (in_valid) state_q <= READ;
				READ: state_q <= CALC;
				CALC: state_q <= DECIDE;
				DECIDE: if (out_free) state_q <= status.is_load ? CLEAR : IDLE;
				CLEAR: if (status.clear_last) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
			if (cmd.write) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end
endmodule

/* design/stochastic_neuron_array_core.sv */
`timescale 1ns / 1ps
// Time-multiplexed array of 1024 stochastic leaky neurons, one item at a time.
// An item is accepted when the core is idle, then passes a memory read state, a
// leak state and a firing decision state that writes the memories and loads the
// result register; a load item then clears its ring slots in a clear state. The
// result register lets the next item enter while a result waits; that item then
// stalls in its decision state until the waiting result is transferred.
// Configuration writes are taken only while the core is idle. Neuron and ring
// memories hold undefined data until each neuron is loaded.
module stochastic_neuron_array_core (
	input logic clk,
	input logic arst_n,
	snac_in_if.sink in_ch,
	snac_out_if.source out_ch,
	snac_cfg_if.sink cfg
);
	import snac_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;
	out_item_t result;

	assign cfg.ready = in_ch.ready;

	snac_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd)
	);

	snac_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_item(in_ch.data), .cfg_item(cfg.data),
		.cfg_we(cfg.valid && cfg.ready), .result(result)
	);

	assign out_ch.data = result;
endmodule
